/* hdl/assert_macros.svh */
// assertion helpers shared by the free stack and the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/bmft_pkg.sv */
//------------------------------------------------------------------------------
// bmft_pkg
// Constants, codes and control structs of the block mapped translation layer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmft_pkg;

  localparam int PAGES    = 8;
  localparam int OFF_W    = 3;
  localparam int LBLK     = 60;
  localparam int PBLK     = 64;
  localparam int BLK_W    = 6;
  localparam int PAGE_W   = 9;
  localparam int FILL_W   = 4;
  localparam int CNT_W    = 7;
  localparam int SECTORS  = LBLK * PAGES;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_UNMAPPED = 3'd1,
    CMD_PROGRAM  = 3'd2,
    CMD_COPY     = 3'd3,
    CMD_ERASE    = 3'd4,
    CMD_NOFREE   = 3'd5,
    CMD_RANGE    = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_RADDR,
    S_RCMP,
    S_POP,
    S_MADDR,
    S_MCMP,
    S_CSEL,
    S_CRD,
    S_CWR,
    S_ERASE,
    S_PROG,
    S_SOLE
  } state_t;

  // page tag store access
  typedef struct packed {
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    logic [PAGE_W-1:0] wr_data;
  } tag_ctl_t;

  // tag compare results
  typedef struct packed {
    logic [PAGE_W-1:0] tag;
    logic              lbn_hit;
    logic              lsn_hit;
  } tag_stat_t;

  // free stack requests
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [BLK_W-1:0] push_blk;
  } fs_ctl_t;

endpackage

`default_nettype wire

/* hdl/bmft_if.sv */
//------------------------------------------------------------------------------
// bmft_if
// Valid/ready channels for requests and flash commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bmft_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [8:0] lsn;
  modport source (output valid, mode, lsn, input ready);
  modport sink (input valid, mode, lsn, output ready);
endinterface

interface bmft_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [8:0] page;
  logic [8:0] source_page;
  logic [5:0] block;
  logic       last;
  modport source (output valid, command, page, source_page, block, last, input ready);
  modport sink (input valid, command, page, source_page, block, last, output ready);
endinterface

`default_nettype wire

/* hdl/bmft_tag_store.sv */
//------------------------------------------------------------------------------
// bmft_tag_store
// Page tag memory with registered read and the shared tag compare unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmft_tag_store (
  input  wire logic                     clk,
  input  wire bmft_pkg::tag_ctl_t       ctl,
  input  wire logic [8:0]               lsn,
  output bmft_pkg::tag_stat_t           stat
);
  import bmft_pkg::*;

  logic [PAGE_W-1:0] mem [PBLK*PAGES];
  logic [PAGE_W-1:0] rd_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_q <= mem[ctl.rd_addr];
  end

  // compare against the request sector and its logical block
  always_comb begin
    stat.tag     = rd_q;
    stat.lbn_hit = (rd_q[PAGE_W-1:OFF_W] == lsn[PAGE_W-1:OFF_W]);
    stat.lsn_hit = (rd_q == lsn);
  end

endmodule

`default_nettype wire

/* hdl/bmft_free_stack.sv */
//------------------------------------------------------------------------------
// bmft_free_stack
// LIFO of free physical blocks; unwritten entries read as their reset block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmft_free_stack (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bmft_pkg::fs_ctl_t           ctl,
  output logic [bmft_pkg::CNT_W-1:0]       count,
  output logic [bmft_pkg::BLK_W-1:0]       top
);
  import bmft_pkg::*;

  logic [BLK_W-1:0] mem [PBLK];
  logic [PBLK-1:0]  vld;
  logic [BLK_W-1:0] mem_q;
  logic [BLK_W-1:0] dflt_q;
  logic             sel_q;
  logic [BLK_W-1:0] top_addr;

  assign top_addr = BLK_W'(count - CNT_W'(1));

  // count and written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(PBLK);
      vld   <= '0;
    end else if (ctl.pop) begin
      count <= count - CNT_W'(1);
    end else if (ctl.push && count < CNT_W'(PBLK)) begin
      vld[count[BLK_W-1:0]] <= 1'b1;
      count <= count + CNT_W'(1);
    end
  end

  // storage and registered top read
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.pop && count < CNT_W'(PBLK)) begin
      mem[count[BLK_W-1:0]] <= ctl.push_blk;
    end
    mem_q  <= mem[top_addr];
    sel_q  <= vld[top_addr];
    dflt_q <= ~top_addr;
  end

  assign top = sel_q ? mem_q : dflt_q;

  `ASSERT_IMPL(a_pop_nonempty, ctl.pop, count != '0)
  `ASSERT_IMPL(a_count_max, 1'b1, count <= CNT_W'(PBLK))
  `ASSERT_NEXT(a_pop_dec, ctl.pop, count == $past(count) - CNT_W'(1))

endmodule

`default_nettype wire

/* hdl/block_mapped_flash_translation.sv */
// a read compares the tag of every filled page of its block (fill up to 8);
// a write to a full block merges first, copying up to 7 pages to a new block
// one request at a time: the sequencer walks page tags through one compare unit
// and one tag memory read port, so a new request is taken only once the last is done
// reset: map valid flags and free stack count clear at once, no clearing pass;
// tag and map memories need no reset
//------------------------------------------------------------------------------
// block_mapped_flash_translation
// Block mapped translation layer: turns sector requests into flash commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module block_mapped_flash_translation (
  input wire logic  clk,
  input wire logic  rst,
  bmft_req_if.sink  req,
  bmft_rsp_if.source rsp
);
  import bmft_pkg::*;

  state_t st, st_next;

  logic                mode_q;
  logic [PAGE_W-1:0]   lsn_q;
  logic [BLK_W-1:0]    lbn;
  logic [BLK_W-1:0]    pbn, nb;
  logic [FILL_W-1:0]   fill, j, n;
  logic [PAGES-1:0]    seen;
  logic [OFF_W-1:0]    newest [PAGES];
  logic                found;
  logic [PAGE_W-1:0]   hit;
  cmd_t                sole_cmd;
  logic [PAGE_W-1:0]   sole_page;
  logic                merging;

  logic [LBLK-1:0]     map_valid;
  logic [BLK_W-1:0]    map_mem  [LBLK];
  logic [FILL_W-1:0]   fill_mem [LBLK];
  logic [BLK_W-1:0]    map_q;
  logic [FILL_W-1:0]   fill_q;
  logic [BLK_W-1:0]    rd_lbn;

  logic                out_valid, o_last;
  cmd_t                o_cmd;
  logic [PAGE_W-1:0]   o_page, o_src;
  logic [BLK_W-1:0]    o_blk;
  logic                can_emit;

  tag_ctl_t  tctl;
  tag_stat_t tstat;
  fs_ctl_t   fctl;
  logic [CNT_W-1:0] fcount;
  logic [BLK_W-1:0] ftop;

  assign lbn      = lsn_q[PAGE_W-1:OFF_W];
  assign can_emit = !out_valid || rsp.ready;
  assign req.ready = (st == S_IDLE);

  bmft_tag_store u_tag (.clk(clk), .ctl(tctl), .lsn(lsn_q), .stat(tstat));
  bmft_free_stack u_fs (.clk(clk), .rst(rst), .ctl(fctl), .count(fcount), .top(ftop));

  // map memories, read address follows the incoming request in idle, then the held one
  always_comb begin
    if (st == S_IDLE) begin
      rd_lbn = (req.lsn < PAGE_W'(SECTORS)) ? req.lsn[PAGE_W-1:OFF_W] : '0;
    end else begin
      rd_lbn = (lsn_q < PAGE_W'(SECTORS)) ? lbn : '0;
    end
  end

  always_ff @(posedge clk) begin
    map_q  <= map_mem[rd_lbn];
    fill_q <= fill_mem[rd_lbn];
    if (st == S_POP && !merging) begin
      map_mem[lbn] <= ftop;
    end else if (st == S_ERASE && can_emit) begin
      map_mem[lbn] <= nb;
    end
    if (st == S_PROG && can_emit) begin
      fill_mem[lbn] <= fill + FILL_W'(1);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // next state, memory and stack requests
  always_comb begin
    st_next      = st;
    tctl.rd_addr = {pbn, j[OFF_W-1:0]};
    tctl.wr_en   = 1'b0;
    tctl.wr_addr = {nb, n[OFF_W-1:0]};
    tctl.wr_data = tstat.tag;
    fctl.pop     = 1'b0;
    fctl.push    = 1'b0;
    fctl.push_blk = pbn;
    unique case (st)
      S_IDLE: begin
        if (req.valid) st_next = S_LOOK;
      end
      S_LOOK: begin
        if (lsn_q >= PAGE_W'(SECTORS)) begin
          st_next = S_SOLE;
        end else if (!mode_q) begin
          st_next = (!map_valid[lbn] || fill_q == '0) ? S_SOLE : S_RADDR;
        end else if (!map_valid[lbn] || fill_q >= FILL_W'(PAGES)) begin
          st_next = (fcount == '0) ? S_SOLE : S_POP;
        end else begin
          st_next = S_PROG;
        end
      end
      S_RADDR: st_next = S_RCMP;
      S_RCMP: begin
        st_next = (j + FILL_W'(1) == fill) ? S_SOLE : S_RADDR;
      end
      S_POP: begin
        fctl.pop = 1'b1;
        st_next  = merging ? S_MADDR : S_PROG;
      end
      S_MADDR: st_next = S_MCMP;
      S_MCMP: st_next = (j == '0) ? S_CSEL : S_MADDR;
      S_CSEL: begin
        if (j == FILL_W'(PAGES)) st_next = S_ERASE;
        else if (seen[j[OFF_W-1:0]]) st_next = S_CRD;
      end
      S_CRD: begin
        tctl.rd_addr = {pbn, newest[j[OFF_W-1:0]]};
        st_next = S_CWR;
      end
      S_CWR: begin
        tctl.rd_addr = {pbn, newest[j[OFF_W-1:0]]};
        if (can_emit) begin
          tctl.wr_en = 1'b1;
          st_next    = S_CSEL;
        end
      end
      S_ERASE: begin
        if (can_emit) begin
          fctl.push = 1'b1;
          st_next   = S_PROG;
        end
      end
      S_PROG: begin
        tctl.wr_addr = {pbn, fill[OFF_W-1:0]};
        tctl.wr_data = lsn_q;
        if (can_emit) begin
          tctl.wr_en = 1'b1;
          st_next    = S_IDLE;
        end
      end
      S_SOLE: begin
        if (can_emit) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  // map valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
    end else if (st == S_POP && !merging) begin
      map_valid[lbn] <= 1'b1;
    end
  end

  // sequencer working registers
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        mode_q <= req.mode;
        lsn_q  <= req.lsn;
      end
      S_LOOK: begin
        pbn     <= map_q;
        fill    <= fill_q;
        j       <= '0;
        found   <= 1'b0;
        merging <= map_valid[lbn];
        if (lsn_q >= PAGE_W'(SECTORS)) begin
          sole_cmd <= CMD_RANGE;
        end else if (!mode_q) begin
          sole_cmd <= CMD_UNMAPPED;
        end else begin
          sole_cmd <= CMD_NOFREE;
        end
        sole_page <= '0;
      end
      S_RCMP: begin
        if (tstat.lsn_hit) begin
          found <= 1'b1;
          hit   <= {pbn, j[OFF_W-1:0]};
        end
        if (tstat.lsn_hit) begin
          sole_cmd  <= CMD_READ;
          sole_page <= {pbn, j[OFF_W-1:0]};
        end else begin
          sole_cmd  <= found ? CMD_READ : CMD_UNMAPPED;
          sole_page <= found ? hit : '0;
        end
        j <= j + FILL_W'(1);
      end
      S_POP: begin
        if (merging) begin
          nb   <= ftop;
          j    <= FILL_W'(PAGES - 1);
          seen <= '0;
        end else begin
          pbn  <= ftop;
          fill <= '0;
        end
      end
      S_MCMP: begin
        if (tstat.lbn_hit && !tstat.lsn_hit && !seen[tstat.tag[OFF_W-1:0]]) begin
          seen[tstat.tag[OFF_W-1:0]]   <= 1'b1;
          newest[tstat.tag[OFF_W-1:0]] <= j[OFF_W-1:0];
        end
        if (j == '0) begin
          n <= '0;
        end else begin
          j <= j - FILL_W'(1);
        end
      end
      S_CSEL: begin
        if (j != FILL_W'(PAGES) && !seen[j[OFF_W-1:0]]) j <= j + FILL_W'(1);
      end
      S_CWR: begin
        if (can_emit) begin
          n <= n + FILL_W'(1);
          j <= j + FILL_W'(1);
        end
      end
      S_ERASE: begin
        if (can_emit) begin
          pbn  <= nb;
          fill <= n;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid <= (st == S_CWR) || (st == S_ERASE) || (st == S_PROG) || (st == S_SOLE);
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      case (st)
        S_CWR: begin
          o_cmd  <= CMD_COPY;
          o_page <= {nb, n[OFF_W-1:0]};
          o_src  <= {pbn, newest[j[OFF_W-1:0]]};
          o_blk  <= '0;
          o_last <= 1'b0;
        end
        S_ERASE: begin
          o_cmd  <= CMD_ERASE;
          o_page <= '0;
          o_src  <= '0;
          o_blk  <= pbn;
          o_last <= 1'b0;
        end
        S_PROG: begin
          o_cmd  <= CMD_PROGRAM;
          o_page <= {pbn, fill[OFF_W-1:0]};
          o_src  <= '0;
          o_blk  <= '0;
          o_last <= 1'b1;
        end
        default: begin
          o_cmd  <= sole_cmd;
          o_page <= sole_page;
          o_src  <= '0;
          o_blk  <= '0;
          o_last <= 1'b1;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.command     = o_cmd;
  assign rsp.page        = o_page;
  assign rsp.source_page = o_src;
  assign rsp.block       = o_blk;
  assign rsp.last        = o_last;

  `ASSERT_IMPL(a_prog_room, st == S_PROG, fill < FILL_W'(PAGES))
  `ASSERT_IMPL(a_copy_room, st == S_CWR, n < FILL_W'(PAGES - 1))
  `ASSERT_IMPL(a_pop_avail, st == S_POP, fcount != '0)

endmodule

`default_nettype wire

/* tb/tb_block_mapped_flash_translation.sv */
//------------------------------------------------------------------------------
// tb_block_mapped_flash_translation
// Drives read and write requests for logical sectors into the translation layer,
// predicts the flash command stream from a local copy of map, fill levels, free
// stack and page tags, and compares each returned command field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_block_mapped_flash_translation;
  import bmft_pkg::*;

  typedef struct {
    logic       mode;
    logic [8:0] lsn;
  } request_t;

  typedef struct {
    cmd_t       command;
    logic [8:0] page;
    logic [8:0] source_page;
    logic [5:0] block;
    logic       last;
  } flash_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmft_req_if req ();
  bmft_rsp_if rsp ();

  block_mapped_flash_translation i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // shadow translation state
  logic             mapped[LBLK];
  logic [BLK_W-1:0] phys_of[LBLK];
  int               fill_of[LBLK];
  logic [BLK_W-1:0] free_blocks[PBLK];
  int               free_top;
  logic [PAGE_W-1:0] tag_of[PBLK*PAGES];

  request_t   pending_reqs[$];
  flash_cmd_t expected_cmds[$];
  int         error_count = 0;
  bit         hold_sender = 1'b0;
  int         send_wait = 0;
  int         recv_wait = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_cmd(input cmd_t c, input int pg, input int src, input int blk);
    flash_cmd_t f;
    f.command = c;
    f.page = pg[8:0];
    f.source_page = src[8:0];
    f.block = blk[5:0];
    f.last = 1'b0;
    expected_cmds.push_back(f);
  endtask

  task automatic close_request();
    expected_cmds[expected_cmds.size()-1].last = 1'b1;
  endtask

  task automatic reset_shadow();
    for (int i = 0; i < LBLK; i++) begin
      mapped[i] = 1'b0;
      fill_of[i] = 0;
      phys_of[i] = '0;
    end
    for (int i = 0; i < PBLK; i++) free_blocks[i] = BLK_W'(PBLK - 1 - i);
    free_top = PBLK;
  endtask

  // work out the commands caused by one request and update the shadow state
  task automatic translate_request(input request_t r);
    int lbn, pbn, fill, nb, n, t, o, hit;
    bit found;
    bit seen[PAGES];
    int newest[PAGES];
    lbn = r.lsn / PAGES;
    if (r.lsn >= SECTORS) begin
      push_cmd(CMD_RANGE, 0, 0, 0);
    end else if (!r.mode) begin
      found = 0;
      hit = 0;
      if (mapped[lbn]) begin
        pbn = phys_of[lbn];
        for (int i = 0; i < fill_of[lbn] && i < PAGES; i++)
          if (tag_of[pbn*PAGES+i] == r.lsn) begin
            found = 1;
            hit = pbn*PAGES + i;
          end
      end
      if (found) push_cmd(CMD_READ, hit, 0, 0);
      else push_cmd(CMD_UNMAPPED, 0, 0, 0);
    end else begin
      if (!mapped[lbn] && free_top == 0) begin
        push_cmd(CMD_NOFREE, 0, 0, 0);
        close_request();
        return;
      end
      if (!mapped[lbn]) begin
        free_top--;
        phys_of[lbn] = free_blocks[free_top];
        mapped[lbn] = 1'b1;
        fill_of[lbn] = 0;
      end
      pbn = phys_of[lbn];
      fill = fill_of[lbn];
      if (fill >= PAGES) begin
        if (free_top == 0) begin
          push_cmd(CMD_NOFREE, 0, 0, 0);
          close_request();
          return;
        end
        free_top--;
        nb = free_blocks[free_top];
        for (int j = 0; j < PAGES; j++) seen[j] = 0;
        // newest copy of every other sector of this block
        for (int j = PAGES - 1; j >= 0; j--) begin
          t = tag_of[pbn*PAGES+j];
          o = t % PAGES;
          if (t / PAGES == lbn && t != r.lsn && !seen[o]) begin
            seen[o] = 1;
            newest[o] = j;
          end
        end
        n = 0;
        for (int j = 0; j < PAGES; j++)
          if (seen[j]) begin
            tag_of[nb*PAGES+n] = tag_of[pbn*PAGES+newest[j]];
            push_cmd(CMD_COPY, nb*PAGES + n, pbn*PAGES + newest[j], 0);
            n++;
          end
        push_cmd(CMD_ERASE, 0, 0, pbn);
        if (free_top < PBLK) begin
          free_blocks[free_top] = BLK_W'(pbn);
          free_top++;
        end
        pbn = nb;
        phys_of[lbn] = BLK_W'(nb);
        fill = n;
      end
      tag_of[pbn*PAGES+fill] = r.lsn;
      push_cmd(CMD_PROGRAM, pbn*PAGES + fill, 0, 0);
      fill_of[lbn] = fill + 1;
    end
    close_request();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.mode <= 1'b0;
      req.lsn <= '0;
      send_wait <= $urandom_range(0, 11);
    end else if (req.valid && !req.ready) begin
      // hold the item until accepted
    end else begin
      int gap;
      gap = send_wait;
      if (req.valid) begin
        translate_request('{mode: req.mode, lsn: req.lsn});
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (gap > 0 || hold_sender || pending_reqs.size() == 0) begin
        req.valid <= 1'b0;
        send_wait <= (gap > 0) ? gap - 1 : 0;
      end else begin
        request_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.mode <= r.mode;
        req.lsn <= r.lsn;
        send_wait <= 0;
      end
    end
  end

  // command monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_wait <= $urandom_range(0, 11);
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected command %0d", rsp.command));
        end else begin
          flash_cmd_t e;
          e = expected_cmds.pop_front();
          if (rsp.command !== e.command)
            report_mismatch($sformatf("command %0d, want %0d", rsp.command, e.command));
          if (rsp.page !== e.page)
            report_mismatch($sformatf("page %0d, want %0d", rsp.page, e.page));
          if (rsp.source_page !== e.source_page)
            report_mismatch($sformatf("source_page %0d, want %0d",
                                      rsp.source_page, e.source_page));
          if (rsp.block !== e.block)
            report_mismatch($sformatf("block %0d, want %0d", rsp.block, e.block));
          if (rsp.last !== e.last)
            report_mismatch($sformatf("last %0d, want %0d", rsp.last, e.last));
        end
        recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
        rsp.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(input bit m, input int s);
    request_t r;
    r.mode = m;
    r.lsn = s[8:0];
    pending_reqs.push_back(r);
  endtask

  // stimulus
  initial begin
    int lb, burst;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: range, unmapped, fill, reread, merge with rewrite
    add_req(1'b0, 0);
    add_req(1'b0, 479);
    add_req(1'b0, 480);
    add_req(1'b1, 511);
    add_req(1'b1, 256);
    add_req(1'b0, 256);
    add_req(1'b0, 257);
    for (int i = 0; i < 8; i++) add_req(1'b1, 472 + (i % 3));
    add_req(1'b0, 473);
    add_req(1'b1, 473);
    add_req(1'b1, 479);
    add_req(1'b0, 472);
    for (int i = 0; i < 5; i++) add_req(1'b1, 8 + i);

    // let everything drain with the sender held
    while (pending_reqs.size() != 0 || req.valid) @(posedge clk);
    hold_sender = 1'b1;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;

    // random: mostly write bursts into few blocks to force merges
    while (pending_reqs.size() < 214) begin
      lb = $urandom_range(0, LBLK - 1);
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(0, 9))
          0: add_req($urandom_range(0, 1), $urandom_range(SECTORS, 511));
          1, 2: add_req(1'b0, lb*PAGES + $urandom_range(0, PAGES - 1));
          3: add_req($urandom_range(0, 1), $urandom_range(0, 511));
          default: add_req(1'b1, lb*PAGES + $urandom_range(0, 3));
        endcase
      end
    end
    // map every logical block, then rewrite a few low sectors
    for (int i = 0; i < LBLK; i++) add_req(1'b1, i*PAGES + $urandom_range(0, 7));
    for (int i = 0; i < 12; i++) add_req(1'b1, $urandom_range(0, 7) * PAGES + 1);

    while (pending_reqs.size() != 0 || req.valid) @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_block_mapped_flash_translation: clean");
    end else begin
      $display("tb_block_mapped_flash_translation: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_block_mapped_flash_translation: errors");
    $finish;
  end

endmodule

`default_nettype wire

/* block_mapped_flash_translation.f */
+incdir+hdl
hdl/bmft_pkg.sv
hdl/bmft_if.sv
hdl/bmft_tag_store.sv
hdl/bmft_free_stack.sv
hdl/block_mapped_flash_translation.sv
tb/tb_block_mapped_flash_translation.sv
